// ===== sv/voxel_ground_classifier_assert.svh =====
// Assertion macros for the voxel ground classifier RTL, used by vgc_back.
// Depends on signals named clk and rst_n in the module that uses them.
`ifndef VOXEL_GROUND_CLASSIFIER_ASSERT_SVH
`define VOXEL_GROUND_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define VGC_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define VGC_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ===== sv/vgc_pkg.sv =====
// Shared types and constants of the voxel ground classifier.
// No dependencies; every module file uses it by scoped names.
package vgc_pkg;

  localparam int MAX_POINTS  = 4096;
  localparam int VOXEL_SLOTS = 1024;
  localparam int PROBE_LIMIT = 16;

  localparam int PT_AW   = $clog2(MAX_POINTS);
  localparam int PLD_W   = PT_AW + 1;
  localparam int VOX_AW  = $clog2(VOXEL_SLOTS);
  localparam int CNT_W   = VOX_AW + 1;
  localparam int COORD_W = 21;
  localparam int KEY_W   = 3 * COORD_W;
  localparam int COUNT_W = 13;
  localparam int IDX_W   = 12;
  localparam int CFG_W   = 16;
  localparam int DIV_STEPS = COORD_W;
  localparam int STEP_W  = $clog2(DIV_STEPS);

  localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

  localparam logic [26:0] HASH_X = 27'd73856093;
  localparam logic [26:0] HASH_Y = 27'd19349663;
  localparam logic [26:0] HASH_Z = 27'd83492791;

  localparam logic [1:0] CFG_LEAF   = 2'd0;
  localparam logic [1:0] CFG_THRESH = 2'd1;
  localparam logic [1:0] CFG_MINPTS = 2'd2;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_TABLE_FULL = 2'd1,
    ST_STORE_FULL = 2'd2,
    ST_NOT_LOADED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    LBL_KEPT   = 2'd0,
    LBL_GROUND = 2'd1,
    LBL_SPARSE = 2'd2
  } label_t;

  typedef struct packed {
    req_t               req;
    logic [KEY_W-1:0]   key;
    logic [COORD_W-1:0] z;
    logic [VOX_AW-1:0]  hash;
    logic [IDX_W-1:0]   pidx;
  } q_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
    logic [COORD_W-1:0] min_z;
    logic [COORD_W-1:0] max_z;
  } vox_entry_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_KEY,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_INIT,
    B_IDLE,
    B_ADD_RD,
    B_ADD_CHK,
    B_LBL_RD1,
    B_LBL_RD2,
    B_LBL_EVAL,
    B_CLR
  } back_state_t;

endpackage

// ===== sv/vgc_front.sv =====
// Front end: takes requests, divides coordinates by the leaf size and hashes the key.
// Depends on vgc_pkg; feeds vgc_queue.
module vgc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  vgc_pkg::req_t                 req,
  input  logic signed [vgc_pkg::COORD_W-1:0] x_mm,
  input  logic signed [vgc_pkg::COORD_W-1:0] y_mm,
  input  logic signed [vgc_pkg::COORD_W-1:0] z_mm,
  input  logic [vgc_pkg::IDX_W-1:0]     pidx,
  input  logic [vgc_pkg::CFG_W-1:0]     leaf,
  input  vgc_pkg::q_stat_t              qs,
  output logic                          push,
  output vgc_pkg::q_entry_t             push_data,
  output logic                          busy
);

  vgc_pkg::front_state_t state_r, state_nxt;
  vgc_pkg::req_t req_r;
  logic [vgc_pkg::COORD_W-1:0] z_r;
  logic [vgc_pkg::IDX_W-1:0]   pidx_r;
  logic [vgc_pkg::CFG_W-1:0]   leaf_r;
  logic [vgc_pkg::STEP_W-1:0]  step_r;
  logic [vgc_pkg::KEY_W-1:0]   key_r;
  logic [vgc_pkg::COORD_W-1:0] mag_r [3];
  logic [vgc_pkg::COORD_W-1:0] quo_r [3];
  logic [vgc_pkg::CFG_W-1:0]   rem_r [3];
  logic                        neg_r [3];

  logic [vgc_pkg::COORD_W-1:0] coord [3];
  logic [vgc_pkg::COORD_W-1:0] mag_nxt [3];
  logic [vgc_pkg::COORD_W-1:0] quo_nxt [3];
  logic [vgc_pkg::CFG_W-1:0]   rem_nxt [3];
  logic [vgc_pkg::COORD_W-1:0] sq [3];
  logic [vgc_pkg::CFG_W:0]     rem_sh [3];
  logic                        last_step;

  logic [vgc_pkg::VOX_AW-1:0]   ux, uy, uz;
  logic [2*vgc_pkg::VOX_AW-1:0] px, py, pz;

  assign coord[0] = x_mm;
  assign coord[1] = y_mm;
  assign coord[2] = z_mm;
  assign last_step = (step_r == vgc_pkg::STEP_W'(vgc_pkg::DIV_STEPS - 1));

  // One restoring quotient bit per cycle on each of the three axes.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem_sh[i] = {rem_r[i], mag_r[i][vgc_pkg::COORD_W-1]};
      mag_nxt[i] = {mag_r[i][vgc_pkg::COORD_W-2:0], 1'b0};
      if (rem_sh[i] >= {1'b0, leaf_r}) begin
        rem_nxt[i] = vgc_pkg::CFG_W'(rem_sh[i] - {1'b0, leaf_r});
        quo_nxt[i] = {quo_r[i][vgc_pkg::COORD_W-2:0], 1'b1};
      end else begin
        rem_nxt[i] = rem_sh[i][vgc_pkg::CFG_W-1:0];
        quo_nxt[i] = {quo_r[i][vgc_pkg::COORD_W-2:0], 1'b0};
      end
      sq[i] = neg_r[i] ? (~quo_r[i] + 1'b1) : quo_r[i];
    end
  end

  // Only the low index bits of each product reach the slot number.
  assign ux = key_r[2*vgc_pkg::COORD_W +: vgc_pkg::VOX_AW];
  assign uy = key_r[vgc_pkg::COORD_W +: vgc_pkg::VOX_AW];
  assign uz = key_r[0 +: vgc_pkg::VOX_AW];
  assign px = ux * vgc_pkg::HASH_X[vgc_pkg::VOX_AW-1:0];
  assign py = uy * vgc_pkg::HASH_Y[vgc_pkg::VOX_AW-1:0];
  assign pz = uz * vgc_pkg::HASH_Z[vgc_pkg::VOX_AW-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vgc_pkg::F_IDLE: begin
        if (start) begin
          state_nxt = (req == vgc_pkg::REQ_ADD) ? vgc_pkg::F_DIV : vgc_pkg::F_PUSH;
        end
      end
      vgc_pkg::F_DIV:  if (last_step) state_nxt = vgc_pkg::F_KEY;
      vgc_pkg::F_KEY:  state_nxt = vgc_pkg::F_PUSH;
      vgc_pkg::F_PUSH: if (!qs.full) state_nxt = vgc_pkg::F_IDLE;
      default:         state_nxt = vgc_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    busy = (state_r != vgc_pkg::F_IDLE);
    push = (state_r == vgc_pkg::F_PUSH) && !qs.full;
    push_data.req  = req_r;
    push_data.key  = key_r;
    push_data.z    = z_r;
    push_data.hash = px[vgc_pkg::VOX_AW-1:0] ^ py[vgc_pkg::VOX_AW-1:0]
                     ^ pz[vgc_pkg::VOX_AW-1:0];
    push_data.pidx = pidx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vgc_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      vgc_pkg::F_IDLE: begin
        req_r  <= req;
        z_r    <= z_mm;
        pidx_r <= pidx;
        leaf_r <= (leaf == '0) ? vgc_pkg::CFG_W'(1) : leaf;
        step_r <= '0;
        for (int i = 0; i < 3; i++) begin
          neg_r[i] <= coord[i][vgc_pkg::COORD_W-1];
          mag_r[i] <= coord[i][vgc_pkg::COORD_W-1] ? (~coord[i] + 1'b1) : coord[i];
          rem_r[i] <= '0;
          quo_r[i] <= '0;
        end
      end
      vgc_pkg::F_DIV: begin
        step_r <= step_r + 1'b1;
        for (int i = 0; i < 3; i++) begin
          mag_r[i] <= mag_nxt[i];
          rem_r[i] <= rem_nxt[i];
          quo_r[i] <= quo_nxt[i];
        end
      end
      vgc_pkg::F_KEY:  key_r <= {sq[0], sq[1], sq[2]};
      vgc_pkg::F_PUSH: ;
      default:         ;
    endcase
  end

endmodule

// ===== sv/vgc_queue.sv =====
// Two-entry request queue between the front end and the back end.
// Depends on vgc_pkg for the entry and status types.
module vgc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  vgc_pkg::q_entry_t push_data,
  input  logic              pop,
  output vgc_pkg::q_entry_t head,
  output vgc_pkg::q_stat_t  qs
);

  vgc_pkg::q_entry_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign head     = mem_r[rd_ptr_r];
  assign qs.empty = (cnt_r == 2'd0);
  assign qs.full  = (cnt_r == 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== sv/vgc_back.sv =====
// Back end: voxel hash table, point slot store, labeling and clearing.
// Depends on vgc_pkg and the assertion macro header; drains vgc_queue.
`include "voxel_ground_classifier_assert.svh"
module vgc_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  vgc_pkg::q_entry_t          head,
  input  vgc_pkg::q_stat_t           qs,
  input  logic [vgc_pkg::CFG_W-1:0]  thresh,
  input  logic [vgc_pkg::COUNT_W-1:0] min_points,
  output logic                       pop,
  output logic                       busy,
  output logic                       out_valid,
  output vgc_pkg::status_t           out_status,
  output logic [vgc_pkg::IDX_W-1:0]  out_point_number,
  output vgc_pkg::label_t            out_label
);

  vgc_pkg::vox_entry_t vox_mem [vgc_pkg::VOXEL_SLOTS];
  logic [vgc_pkg::VOX_AW-1:0] pt_mem [vgc_pkg::MAX_POINTS];

  vgc_pkg::back_state_t state_r, state_nxt;
  vgc_pkg::q_entry_t    cmd_r, cmd_nxt;
  logic [vgc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [vgc_pkg::PLD_W-1:0] loaded_r, loaded_nxt;
  logic                      out_valid_r, out_valid_nxt;
  vgc_pkg::status_t          status_r, status_nxt;
  logic [vgc_pkg::IDX_W-1:0] num_r, num_nxt;
  vgc_pkg::label_t           label_r, label_nxt;

  vgc_pkg::vox_entry_t       vox_rd_q, vox_wdata;
  logic [vgc_pkg::VOX_AW-1:0] vox_addr, probe_slot, pt_rd_q;
  logic                      vox_we, pt_we;
  logic [vgc_pkg::PT_AW-1:0] pt_addr;

  logic store_full, not_loaded, key_hit, probe_last, sweep_last;
  logic z_idx_le0, spread_ok;
  logic signed [vgc_pkg::COORD_W:0] spread;

  assign probe_slot = cmd_r.hash + cnt_r[vgc_pkg::VOX_AW-1:0];
  assign store_full = (loaded_r >= vgc_pkg::PLD_W'(vgc_pkg::MAX_POINTS));
  assign not_loaded = ({1'b0, head.pidx} >= vgc_pkg::PLD_W'(loaded_r));
  assign key_hit    = vox_rd_q.valid && (vox_rd_q.key == cmd_r.key);
  assign probe_last = (cnt_r == vgc_pkg::CNT_W'(vgc_pkg::PROBE_LIMIT - 1));
  assign sweep_last = (cnt_r == vgc_pkg::CNT_W'(vgc_pkg::VOXEL_SLOTS - 1));
  assign z_idx_le0  = vox_rd_q.key[vgc_pkg::COORD_W-1] ||
                      (vox_rd_q.key[vgc_pkg::COORD_W-1:0] == '0);
  assign spread     = $signed({vox_rd_q.max_z[vgc_pkg::COORD_W-1], vox_rd_q.max_z})
                    - $signed({vox_rd_q.min_z[vgc_pkg::COORD_W-1], vox_rd_q.min_z});
  assign spread_ok  = !spread[vgc_pkg::COORD_W] &&
                      (spread[vgc_pkg::COORD_W-1:0] <=
                       vgc_pkg::COORD_W'({5'd0, thresh}));

  assign busy             = (state_r != vgc_pkg::B_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_point_number = num_r;
  assign out_label        = label_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vgc_pkg::B_INIT, vgc_pkg::B_CLR: begin
        if (sweep_last) state_nxt = vgc_pkg::B_IDLE;
      end
      vgc_pkg::B_IDLE: begin
        if (!qs.empty) begin
          unique case (head.req)
            vgc_pkg::REQ_ADD:   if (!store_full) state_nxt = vgc_pkg::B_ADD_RD;
            vgc_pkg::REQ_READ:  if (!not_loaded) state_nxt = vgc_pkg::B_LBL_RD1;
            vgc_pkg::REQ_CLEAR: state_nxt = vgc_pkg::B_CLR;
            vgc_pkg::REQ_NONE:  state_nxt = vgc_pkg::B_IDLE;
            default:            state_nxt = vgc_pkg::B_IDLE;
          endcase
        end
      end
      vgc_pkg::B_ADD_RD:  state_nxt = vgc_pkg::B_ADD_CHK;
      vgc_pkg::B_ADD_CHK: begin
        if (!vox_rd_q.valid || key_hit || probe_last) state_nxt = vgc_pkg::B_IDLE;
        else state_nxt = vgc_pkg::B_ADD_RD;
      end
      vgc_pkg::B_LBL_RD1:  state_nxt = vgc_pkg::B_LBL_RD2;
      vgc_pkg::B_LBL_RD2:  state_nxt = vgc_pkg::B_LBL_EVAL;
      vgc_pkg::B_LBL_EVAL: state_nxt = vgc_pkg::B_IDLE;
      default:             state_nxt = vgc_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop           = 1'b0;
    cmd_nxt       = cmd_r;
    cnt_nxt       = cnt_r;
    loaded_nxt    = loaded_r;
    out_valid_nxt = 1'b0;
    status_nxt    = vgc_pkg::ST_OK;
    num_nxt       = '0;
    label_nxt     = vgc_pkg::LBL_KEPT;
    vox_addr      = probe_slot;
    vox_we        = 1'b0;
    vox_wdata     = vox_rd_q;
    pt_we         = 1'b0;
    pt_addr       = loaded_r[vgc_pkg::PT_AW-1:0];
    unique case (state_r)
      vgc_pkg::B_INIT, vgc_pkg::B_CLR: begin
        vox_addr        = cnt_r[vgc_pkg::VOX_AW-1:0];
        vox_we          = 1'b1;
        vox_wdata.valid = 1'b0;
        cnt_nxt         = cnt_r + 1'b1;
        if (sweep_last) begin
          loaded_nxt    = '0;
          out_valid_nxt = (state_r == vgc_pkg::B_CLR);
        end
      end
      vgc_pkg::B_IDLE: begin
        cnt_nxt = '0;
        if (!qs.empty) begin
          pop     = 1'b1;
          cmd_nxt = head;
          unique case (head.req)
            vgc_pkg::REQ_ADD: begin
              if (store_full) begin
                out_valid_nxt = 1'b1;
                status_nxt    = vgc_pkg::ST_STORE_FULL;
              end
            end
            vgc_pkg::REQ_READ: begin
              if (not_loaded) begin
                out_valid_nxt = 1'b1;
                status_nxt    = vgc_pkg::ST_NOT_LOADED;
                num_nxt       = head.pidx;
              end
            end
            vgc_pkg::REQ_CLEAR: ;
            vgc_pkg::REQ_NONE:  out_valid_nxt = 1'b1;
            default:            ;
          endcase
        end
      end
      vgc_pkg::B_ADD_RD: ;
      vgc_pkg::B_ADD_CHK: begin
        if (!vox_rd_q.valid || key_hit) begin
          vox_we = 1'b1;
          if (key_hit) begin
            if (vox_rd_q.count != vgc_pkg::COUNT_SAT) vox_wdata.count = vox_rd_q.count + 1'b1;
            if ($signed(cmd_r.z) < $signed(vox_rd_q.min_z)) vox_wdata.min_z = cmd_r.z;
            if ($signed(cmd_r.z) > $signed(vox_rd_q.max_z)) vox_wdata.max_z = cmd_r.z;
          end else begin
            vox_wdata.valid = 1'b1;
            vox_wdata.key   = cmd_r.key;
            vox_wdata.count = vgc_pkg::COUNT_W'(1);
            vox_wdata.min_z = cmd_r.z;
            vox_wdata.max_z = cmd_r.z;
          end
          pt_we         = 1'b1;
          loaded_nxt    = loaded_r + 1'b1;
          out_valid_nxt = 1'b1;
          num_nxt       = loaded_r[vgc_pkg::IDX_W-1:0];
        end else if (probe_last) begin
          out_valid_nxt = 1'b1;
          status_nxt    = vgc_pkg::ST_TABLE_FULL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      vgc_pkg::B_LBL_RD1: pt_addr = cmd_r.pidx[vgc_pkg::PT_AW-1:0];
      vgc_pkg::B_LBL_RD2: vox_addr = pt_rd_q;
      vgc_pkg::B_LBL_EVAL: begin
        out_valid_nxt = 1'b1;
        num_nxt       = cmd_r.pidx;
        priority if (vox_rd_q.count < min_points) label_nxt = vgc_pkg::LBL_SPARSE;
        else if (z_idx_le0 && spread_ok)          label_nxt = vgc_pkg::LBL_GROUND;
        else                                      label_nxt = vgc_pkg::LBL_KEPT;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vgc_pkg::B_INIT;
      cnt_r       <= '0;
      loaded_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      loaded_r    <= loaded_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    status_r <= status_nxt;
    num_r    <= num_nxt;
    label_r  <= label_nxt;
  end

  always_ff @(posedge clk) begin
    if (vox_we) vox_mem[vox_addr] <= vox_wdata;
    vox_rd_q <= vox_mem[vox_addr];
  end

  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[pt_addr] <= probe_slot;
    pt_rd_q <= pt_mem[pt_addr];
  end

  `VGC_ASSERT_NEXT(a_one_cycle_result, out_valid_r, !out_valid_r)
  `VGC_ASSERT_IMPL(a_probe_in_range, state_r == vgc_pkg::B_ADD_CHK,
                   cnt_r < vgc_pkg::CNT_W'(vgc_pkg::PROBE_LIMIT))
  `VGC_ASSERT_IMPL(a_loaded_bound, 1'b1,
                   loaded_r <= vgc_pkg::PLD_W'(vgc_pkg::MAX_POINTS))
  `VGC_ASSERT_NEXT(a_pop_progress, pop, out_valid_r || state_r != vgc_pkg::B_IDLE)

endmodule

// ===== sv/voxel_ground_classifier.sv =====
// Order of work: an add runs 21 divide steps, the key step, the queue hop and the table
// probes, and skips the probes when the point store is full; a read of a loaded point reads
// the point store, then the voxel table, then labels; a clear sweeps the whole voxel table.
// Throughput: one request in flight; busy drops in the cycle the result is out, so the next
// request may be taken at the edge that takes the result. Results cannot be stalled.
// Reset: synchronous active-low rst_n; then a sweep of every slot empties the voxel table, busy high.
module voxel_ground_classifier (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_req_type,
  input  logic signed [vgc_pkg::COORD_W-1:0] in_x_mm,
  input  logic signed [vgc_pkg::COORD_W-1:0] in_y_mm,
  input  logic signed [vgc_pkg::COORD_W-1:0] in_z_mm,
  input  logic [vgc_pkg::IDX_W-1:0]          in_point_index,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic [vgc_pkg::IDX_W-1:0]          out_point_number,
  output logic [1:0]                         out_label,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [vgc_pkg::CFG_W-1:0]          cfg_wdata
);

  // Configuration registers, written directly by the plain write port.
  logic [vgc_pkg::CFG_W-1:0]   leaf_r;
  logic [vgc_pkg::CFG_W-1:0]   thresh_r;
  logic [vgc_pkg::COUNT_W-1:0] minpts_r;

  logic              f_busy, b_busy, push, pop;
  vgc_pkg::q_entry_t push_data, head;
  vgc_pkg::q_stat_t  qs;
  vgc_pkg::status_t  status;
  vgc_pkg::label_t   label;

  // A request is taken only when the front end, the queue and the back end are all idle.
  assign busy       = f_busy || !qs.empty || b_busy;
  assign out_status = status;
  assign out_label  = label;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leaf_r   <= vgc_pkg::CFG_W'(800);
      thresh_r <= vgc_pkg::CFG_W'(150);
      minpts_r <= vgc_pkg::COUNT_W'(10);
    end else if (cfg_we) begin
      unique case (cfg_index)
        vgc_pkg::CFG_LEAF:   leaf_r   <= cfg_wdata;
        vgc_pkg::CFG_THRESH: thresh_r <= cfg_wdata;
        vgc_pkg::CFG_MINPTS: minpts_r <= cfg_wdata[vgc_pkg::COUNT_W-1:0];
        default:             ;
      endcase
    end
  end

  // The front end turns coordinates into a voxel key and a home slot.
  vgc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start && !busy),
    .req       (vgc_pkg::req_t'(in_req_type)),
    .x_mm      (in_x_mm),
    .y_mm      (in_y_mm),
    .z_mm      (in_z_mm),
    .pidx      (in_point_index),
    .leaf      (leaf_r),
    .qs        (qs),
    .push      (push),
    .push_data (push_data),
    .busy      (f_busy)
  );

  // The queue decouples the arithmetic from the table accesses.
  vgc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qs        (qs)
  );

  // The back end owns both memories and produces every result.
  vgc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .qs               (qs),
    .thresh           (thresh_r),
    .min_points       (minpts_r),
    .pop              (pop),
    .busy             (b_busy),
    .out_valid        (out_valid),
    .out_status       (status),
    .out_point_number (out_point_number),
    .out_label        (label)
  );

endmodule
